[src/hrp_pkg.sv]
package hrp_pkg;

  // Longest body that is parsed; anything longer is reported as too long.
  localparam int unsigned MAX_BODY_BYTES = 65535;
  localparam int unsigned COUNT_LIMIT    = MAX_BODY_BYTES + 5;
  localparam int unsigned COUNT_W        = $clog2(COUNT_LIMIT + 1);
  localparam int unsigned BODY_W         = $clog2(MAX_BODY_BYTES + 1);

  localparam int unsigned PREFIX_BYTES   = 4;
  localparam int unsigned MIN_BODY_BYTES = 15;
  localparam int unsigned HTTP_TAG_LEN   = 5;

  localparam int unsigned CODE_W = 10;
  localparam logic [CODE_W-1:0] SUCCESS_CODE_RESET = CODE_W'(200);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK           = 3'd0;
  localparam status_t ST_TOO_SHORT    = 3'd1;
  localparam status_t ST_PREFIX_FAIL  = 3'd2;
  localparam status_t ST_NOT_HTTP     = 3'd3;
  localparam status_t ST_CODE_FAIL    = 3'd4;
  localparam status_t ST_NO_SEPARATOR = 3'd5;
  localparam status_t ST_TOO_LONG     = 3'd6;

  // Snapshot of the per-reply parse state, taken after the current byte.
  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [31:0]        prefix_word;
    logic [2:0]         version_match_count;
    logic [31:0]        code_accumulator;
    logic               code_negative;
    logic               separator_found;
    logic [BODY_W-1:0]  separator_end;
  } reply_state_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] result_code;
    logic [15:0] content_start;
    logic [15:0] content_length;
  } verdict_t;

  function automatic logic [7:0] http_tag(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h48;  // H
      3'd1:    ch = 8'h54;  // T
      3'd2:    ch = 8'h54;  // T
      3'd3:    ch = 8'h50;  // P
      3'd4:    ch = 8'h2f;  // /
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[src/hrp_if.sv]
interface hrp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrp_verdict_if;
  logic                 valid;
  logic                 ready;
  hrp_pkg::status_t     status;
  logic signed [31:0]   result_code;
  logic [15:0]          content_start;
  logic [15:0]          content_length;

  modport source (output valid, output status, output result_code,
                  output content_start, output content_length, input ready);
  modport sink (input valid, input status, input result_code,
                input content_start, input content_length, output ready);
endinterface

[src/hrp_scan.sv]
module hrp_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output hrp_pkg::reply_state_t snap
);

  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_GAP     = 3'd1;
  localparam logic [2:0] PH_LEAD    = 3'd2;
  localparam logic [2:0] PH_DIGITS  = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  localparam int unsigned CW = hrp_pkg::COUNT_W;
  localparam int unsigned BW = hrp_pkg::BODY_W;

  logic [CW-1:0] byte_count;
  logic [31:0]   prefix_word;
  logic [2:0]    token_phase;
  logic [2:0]    version_match_count;
  logic [31:0]   code_accumulator;
  logic          code_negative;
  logic [1:0]    separator_progress;
  logic          separator_found;
  logic [BW-1:0] separator_end;

  logic [CW-1:0] byte_count_next;
  logic [31:0]   prefix_word_next;
  logic [2:0]    token_phase_next;
  logic [2:0]    version_match_count_next;
  logic [31:0]   code_accumulator_next;
  logic          code_negative_next;
  logic [1:0]    separator_progress_next;
  logic          separator_found_next;
  logic [BW-1:0] separator_end_next;

  logic          in_prefix;
  logic          in_body;
  logic [BW-1:0] body_off;
  logic          is_digit;
  logic          is_ctl;
  logic [2:0]    code_phase;
  logic [35:0]   scaled;

  assign in_prefix = byte_count < CW'(hrp_pkg::PREFIX_BYTES);
  assign in_body   = !in_prefix &&
                     (byte_count < CW'(hrp_pkg::MAX_BODY_BYTES + hrp_pkg::PREFIX_BYTES));
  assign body_off  = BW'(byte_count - CW'(hrp_pkg::PREFIX_BYTES));
  assign is_digit  = (data_byte >= hrp_pkg::CHAR_ZERO) && (data_byte <= hrp_pkg::CHAR_NINE);
  assign is_ctl    = (data_byte >= hrp_pkg::CHAR_TAB) && (data_byte <= hrp_pkg::CHAR_CR);

  // The first non-space byte after the version token opens the code token.
  assign code_phase = (token_phase == PH_GAP && data_byte != hrp_pkg::CHAR_SPACE) ?
                      PH_LEAD : token_phase;

  // acc * 10 + digit, saturated at the magnitude of the most negative int32.
  assign scaled = ({4'd0, code_accumulator} << 3) + ({4'd0, code_accumulator} << 1) +
                  36'(data_byte - hrp_pkg::CHAR_ZERO);

  always_comb begin
    byte_count_next          = byte_count;
    prefix_word_next         = prefix_word;
    token_phase_next         = token_phase;
    version_match_count_next = version_match_count;
    code_accumulator_next    = code_accumulator;
    code_negative_next       = code_negative;
    separator_progress_next  = separator_progress;
    separator_found_next     = separator_found;
    separator_end_next       = separator_end;

    if (byte_count < CW'(hrp_pkg::COUNT_LIMIT)) begin
      byte_count_next = byte_count + CW'(1);
    end

    if (in_prefix) begin
      for (int i = 0; i < 4; i++) begin
        if (byte_count[1:0] == 2'(i)) begin
          prefix_word_next[8*i +: 8] = prefix_word[8*i +: 8] | data_byte;
        end
      end
    end else if (in_body) begin
      if (body_off < BW'(hrp_pkg::HTTP_TAG_LEN) && BW'(version_match_count) == body_off &&
          data_byte == hrp_pkg::http_tag(body_off[2:0])) begin
        version_match_count_next = version_match_count + 3'd1;
      end

      if (token_phase == PH_VERSION) begin
        if (data_byte == hrp_pkg::CHAR_SPACE) begin
          token_phase_next = PH_GAP;
        end
      end else if (code_phase == PH_LEAD) begin
        if (data_byte == hrp_pkg::CHAR_SPACE) begin
          token_phase_next = PH_DONE;
        end else if (is_ctl) begin
          token_phase_next = PH_LEAD;
        end else if (data_byte == hrp_pkg::CHAR_PLUS || data_byte == hrp_pkg::CHAR_MINUS) begin
          code_negative_next = (data_byte == hrp_pkg::CHAR_MINUS);
          token_phase_next   = PH_DIGITS;
        end else if (is_digit) begin
          token_phase_next = PH_DIGITS;
          code_accumulator_next = (scaled > 36'h080000000) ? 32'h80000000 : scaled[31:0];
        end else begin
          token_phase_next = PH_DONE;
        end
      end else if (code_phase == PH_DIGITS) begin
        if (is_digit) begin
          code_accumulator_next = (scaled > 36'h080000000) ? 32'h80000000 : scaled[31:0];
        end else begin
          token_phase_next = PH_DONE;
        end
      end

      if (!separator_found) begin
        if (data_byte == hrp_pkg::CHAR_CR) begin
          separator_progress_next = (separator_progress == 2'd2) ? 2'd3 : 2'd1;
        end else if (data_byte == hrp_pkg::CHAR_LF) begin
          if (separator_progress == 2'd1) begin
            separator_progress_next = 2'd2;
          end else if (separator_progress == 2'd3) begin
            separator_found_next    = 1'b1;
            separator_end_next      = body_off + BW'(1);
            separator_progress_next = 2'd0;
          end else begin
            separator_progress_next = 2'd0;
          end
        end else begin
          separator_progress_next = 2'd0;
        end
      end
    end
  end

  always_comb begin
    snap.byte_count          = byte_count_next;
    snap.prefix_word         = prefix_word_next;
    snap.version_match_count = version_match_count_next;
    snap.code_accumulator    = code_accumulator_next;
    snap.code_negative       = code_negative_next;
    snap.separator_found     = separator_found_next;
    snap.separator_end       = separator_end_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_count          <= '0;
      prefix_word         <= '0;
      token_phase         <= PH_VERSION;
      version_match_count <= '0;
      code_accumulator    <= '0;
      code_negative       <= 1'b0;
      separator_progress  <= '0;
      separator_found     <= 1'b0;
      separator_end       <= '0;
    end else if (step) begin
      byte_count          <= byte_count_next;
      prefix_word         <= prefix_word_next;
      token_phase         <= token_phase_next;
      version_match_count <= version_match_count_next;
      code_accumulator    <= code_accumulator_next;
      code_negative       <= code_negative_next;
      separator_progress  <= separator_progress_next;
      separator_found     <= separator_found_next;
      separator_end       <= separator_end_next;
    end
  end

endmodule

[src/hrp_verdict.sv]
module hrp_verdict (
  input  hrp_pkg::reply_state_t       snap,
  input  logic [hrp_pkg::CODE_W-1:0]  success_code,
  output hrp_pkg::verdict_t           verdict
);

  localparam int unsigned CW = hrp_pkg::COUNT_W;

  logic [CW-1:0] body_len;
  logic [CW-1:0] sep_end_wide;
  logic [31:0]   success_wide;
  logic [31:0]   http_code;
  logic [31:0]   start_wide;
  logic [31:0]   length_wide;

  assign body_len     = snap.byte_count - CW'(hrp_pkg::PREFIX_BYTES);
  assign sep_end_wide = CW'(snap.separator_end);
  assign success_wide = 32'(success_code);
  assign start_wide   = 32'(snap.separator_end);
  assign length_wide  = 32'(body_len - sep_end_wide);

  always_comb begin
    if (snap.code_negative) begin
      http_code = 32'd0 - snap.code_accumulator;
    end else if (snap.code_accumulator[31]) begin
      http_code = 32'h7fffffff;
    end else begin
      http_code = snap.code_accumulator;
    end
  end

  always_comb begin
    verdict.status         = hrp_pkg::ST_OK;
    verdict.result_code    = snap.prefix_word;
    verdict.content_start  = 16'd0;
    verdict.content_length = 16'd0;
    if (snap.byte_count < CW'(hrp_pkg::PREFIX_BYTES)) begin
      verdict.status      = hrp_pkg::ST_TOO_SHORT;
      verdict.result_code = 32'd0;
    end else if (body_len > CW'(hrp_pkg::MAX_BODY_BYTES)) begin
      verdict.status = hrp_pkg::ST_TOO_LONG;
    end else if (snap.prefix_word != success_wide) begin
      verdict.status = hrp_pkg::ST_PREFIX_FAIL;
    end else if (body_len < CW'(hrp_pkg::MIN_BODY_BYTES)) begin
      verdict.status = hrp_pkg::ST_TOO_SHORT;
    end else if (snap.version_match_count != 3'(hrp_pkg::HTTP_TAG_LEN)) begin
      verdict.status = hrp_pkg::ST_NOT_HTTP;
    end else begin
      verdict.result_code = http_code;
      if (http_code != success_wide) begin
        verdict.status = hrp_pkg::ST_CODE_FAIL;
      end else if (!snap.separator_found || sep_end_wide >= body_len) begin
        verdict.status = hrp_pkg::ST_NO_SEPARATOR;
      end else begin
        verdict.content_start  = start_wide[15:0];
        verdict.content_length = length_wide[15:0];
      end
    end
  end

endmodule

[src/http_response_header_parser.sv]
// HTTP reply checker. A reply streams in one byte per request on the
// reply_bytes channel, with last_byte set on its final byte, and exactly
// one verdict request leaves on the verdict channel for each reply, after
// which the parser starts afresh. The first four bytes are a little-endian
// signed prefix code; the body behind them must be at least 15 bytes, open
// with "HTTP/", carry a status token equal to success_code and hold a blank
// line (CR LF CR LF) followed by at least one content byte. Bodies longer
// than MAX_BODY_BYTES are reported as too long. The parser sustains one
// byte per clock cycle: every byte goes through one input register and one
// parse step, and the verdict sits in a result register, so the bytes of
// the next reply keep flowing while a verdict waits to be taken; only the
// last byte of that next reply waits for the result register to free up.
// A verdict is loaded when its last byte leaves the input register and can
// be taken from the following cycle on. success_code resets to 200 and is
// written through cfg_we and cfg_data; the user must do so only while no
// reply is in flight, as the parser itself does not enforce this.
module http_response_header_parser (
  input  logic                          clk,
  input  logic                          rst,
  hrp_byte_if.sink                      reply_bytes,
  hrp_verdict_if.source                 verdict,
  input  logic                          cfg_we,
  input  logic [hrp_pkg::CODE_W-1:0]    cfg_data
);

  // Input register: holds one accepted byte until the parse step takes it.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Result register.
  logic              res_valid;
  hrp_pkg::verdict_t res;

  logic [hrp_pkg::CODE_W-1:0] success_code;

  hrp_pkg::reply_state_t snap;
  hrp_pkg::verdict_t     verdict_calc;

  logic res_free;
  logic advance;

  // A byte that ends a reply needs room in the result register; other
  // bytes move on unconditionally.
  assign res_free          = !res_valid || verdict.ready;
  assign advance           = in_valid && (!in_last || res_free);
  assign reply_bytes.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (reply_bytes.ready) begin
      in_valid <= reply_bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (reply_bytes.valid && reply_bytes.ready) begin
      in_byte <= reply_bytes.data_byte;
      in_last <= reply_bytes.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      success_code <= hrp_pkg::SUCCESS_CODE_RESET;
    end else if (cfg_we) begin
      success_code <= cfg_data;
    end
  end

  hrp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .snap      (snap)
  );

  hrp_verdict u_verdict (
    .snap         (snap),
    .success_code (success_code),
    .verdict      (verdict_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && in_last) begin
      res_valid <= 1'b1;
    end else if (verdict.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      res <= verdict_calc;
    end
  end

  assign verdict.valid          = res_valid;
  assign verdict.status         = res.status;
  assign verdict.result_code    = res.result_code;
  assign verdict.content_start  = res.content_start;
  assign verdict.content_length = res.content_length;

endmodule

[bench/http_reply_checker.sv]
`timescale 1ns / 100ps

// Watches the byte and verdict channels of the parser. It predicts every verdict
// from the accepted bytes and compares it with what the parser returns.
module http_reply_checker (
  input  logic                       clk,
  input  logic                       rst,
  hrp_byte_if                        byte_ch,
  hrp_verdict_if                     verdict_ch,
  input  logic                       cfg_we,
  input  logic [hrp_pkg::CODE_W-1:0] cfg_data,
  output int unsigned                fail_count,
  output int unsigned                verdicts_pending
);

  localparam int unsigned CODE_W  = hrp_pkg::CODE_W;
  localparam int unsigned COUNT_W = hrp_pkg::COUNT_W;
  localparam int unsigned BODY_W  = hrp_pkg::BODY_W;

  typedef enum logic [2:0] {
    TOK_VERSION,
    TOK_GAP,
    TOK_LEAD,
    TOK_DIGITS,
    TOK_DONE
  } tok_phase_t;

  localparam logic [39:0] VERSION_TAG = "HTTP/";

  logic [CODE_W-1:0]  success_code;
  logic [COUNT_W-1:0] byte_count;
  logic [31:0]        prefix_word;
  tok_phase_t         tok_phase;
  logic [2:0]         tag_hits;
  logic [31:0]        code_mag;
  logic               code_neg;
  logic [1:0]         crlf_progress;
  logic               blank_line_seen;
  logic [BODY_W-1:0]  header_end;
  hrp_pkg::verdict_t  verdicts_due[$];

  task automatic restart_reply();
    byte_count      = '0;
    prefix_word     = '0;
    tok_phase       = TOK_VERSION;
    tag_hits        = '0;
    code_mag        = '0;
    code_neg        = 1'b0;
    crlf_progress   = '0;
    blank_line_seen = 1'b0;
    header_end      = '0;
  endtask

  // Decimal accumulation that sticks at 2^31 so both signs can saturate.
  task automatic add_digit(input logic [7:0] c);
    logic [35:0] grown;
    grown = {4'b0, code_mag} * 36'd10 + 36'(c - hrp_pkg::CHAR_ZERO);
    if (grown > 36'h0_8000_0000) grown = 36'h0_8000_0000;
    code_mag = grown[31:0];
  endtask

  task automatic code_char(input logic [7:0] c);
    logic digit;
    logic ctl;
    digit = (c >= hrp_pkg::CHAR_ZERO) && (c <= hrp_pkg::CHAR_NINE);
    ctl   = (c >= hrp_pkg::CHAR_TAB) && (c <= hrp_pkg::CHAR_CR);
    case (tok_phase)
      TOK_LEAD: begin
        if (c == hrp_pkg::CHAR_SPACE) begin
          tok_phase = TOK_DONE;
        end else if (c == hrp_pkg::CHAR_PLUS || c == hrp_pkg::CHAR_MINUS) begin
          code_neg  = (c == hrp_pkg::CHAR_MINUS);
          tok_phase = TOK_DIGITS;
        end else if (digit) begin
          tok_phase = TOK_DIGITS;
          add_digit(c);
        end else if (!ctl) begin
          tok_phase = TOK_DONE;
        end
      end
      TOK_DIGITS: begin
        if (digit) add_digit(c);
        else tok_phase = TOK_DONE;
      end
      default: ;
    endcase
  endtask

  task automatic scan_body(input int unsigned k, input logic [7:0] c);
    if (k < hrp_pkg::HTTP_TAG_LEN && tag_hits == k && c == VERSION_TAG[39 - 8*k -: 8])
      tag_hits = tag_hits + 3'd1;

    case (tok_phase)
      TOK_VERSION: if (c == hrp_pkg::CHAR_SPACE) tok_phase = TOK_GAP;
      TOK_GAP: begin
        if (c != hrp_pkg::CHAR_SPACE) begin
          tok_phase = TOK_LEAD;
          code_char(c);
        end
      end
      default: code_char(c);
    endcase

    if (!blank_line_seen) begin
      if (c == hrp_pkg::CHAR_CR) begin
        crlf_progress = (crlf_progress == 2'd2) ? 2'd3 : 2'd1;
      end else if (c == hrp_pkg::CHAR_LF) begin
        if (crlf_progress == 2'd1) begin
          crlf_progress = 2'd2;
        end else if (crlf_progress == 2'd3) begin
          blank_line_seen = 1'b1;
          header_end      = BODY_W'(k + 1);
          crlf_progress   = 2'd0;
        end else begin
          crlf_progress = 2'd0;
        end
      end else begin
        crlf_progress = 2'd0;
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] c, input logic lst);
    hrp_pkg::verdict_t v;
    int unsigned       body_len;
    logic [31:0]       code;
    if (byte_count < hrp_pkg::PREFIX_BYTES)
      prefix_word[8*int'(byte_count) +: 8] = c;
    else if (byte_count - hrp_pkg::PREFIX_BYTES < hrp_pkg::MAX_BODY_BYTES)
      scan_body(byte_count - hrp_pkg::PREFIX_BYTES, c);
    if (byte_count < hrp_pkg::COUNT_LIMIT) byte_count = byte_count + 1'b1;

    if (lst) begin
      v = '0;
      if (byte_count < hrp_pkg::PREFIX_BYTES) begin
        v.status = hrp_pkg::ST_TOO_SHORT;
      end else begin
        body_len      = byte_count - hrp_pkg::PREFIX_BYTES;
        v.result_code = prefix_word;
        if (body_len > hrp_pkg::MAX_BODY_BYTES) begin
          v.status = hrp_pkg::ST_TOO_LONG;
        end else if (prefix_word != 32'(success_code)) begin
          v.status = hrp_pkg::ST_PREFIX_FAIL;
        end else if (body_len < hrp_pkg::MIN_BODY_BYTES) begin
          v.status = hrp_pkg::ST_TOO_SHORT;
        end else if (tag_hits != hrp_pkg::HTTP_TAG_LEN) begin
          v.status = hrp_pkg::ST_NOT_HTTP;
        end else begin
          if (code_neg) code = 32'd0 - code_mag;
          else code = (code_mag > 32'h7fff_ffff) ? 32'h7fff_ffff : code_mag;
          v.result_code = code;
          if (code != 32'(success_code)) begin
            v.status = hrp_pkg::ST_CODE_FAIL;
          end else if (!blank_line_seen || header_end >= body_len) begin
            v.status = hrp_pkg::ST_NO_SEPARATOR;
          end else begin
            v.status         = hrp_pkg::ST_OK;
            v.content_start  = header_end;
            v.content_length = 16'(body_len - header_end);
          end
        end
      end
      verdicts_due.push_back(v);
      restart_reply();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns checker: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_verdict();
    hrp_pkg::verdict_t want;
    if (verdicts_due.size() == 0) begin
      report_mismatch("verdict request with no reply outstanding");
      return;
    end
    want = verdicts_due.pop_front();
    if (verdict_ch.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", verdict_ch.status, want.status));
    if (verdict_ch.result_code !== want.result_code)
      report_mismatch($sformatf("result_code got %0d want %0d",
                                verdict_ch.result_code, $signed(want.result_code)));
    if (verdict_ch.content_start !== want.content_start)
      report_mismatch($sformatf("content_start got %0d want %0d",
                                verdict_ch.content_start, want.content_start));
    if (verdict_ch.content_length !== want.content_length)
      report_mismatch($sformatf("content_length got %0d want %0d",
                                verdict_ch.content_length, want.content_length));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      success_code = hrp_pkg::SUCCESS_CODE_RESET;
      restart_reply();
      verdicts_due.delete();
      fail_count = 0;
      verdicts_pending <= 0;
    end else begin
      if (cfg_we) success_code = cfg_data;
      if (byte_ch.valid && byte_ch.ready) take_byte(byte_ch.data_byte, byte_ch.last_byte);
      if (verdict_ch.valid && verdict_ch.ready) check_verdict();
      verdicts_pending <= verdicts_due.size();
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

// Top of the parser bench. This module only produces stimulus and gives the
// verdict; all prediction and comparison lives in the checker beside the parser.
module tb;

  localparam int unsigned CODE_W = hrp_pkg::CODE_W;

  // Watchdog limit; a correct run stays below it even if every byte ended a reply
  // and every verdict met the slowest taker plus the long hold.
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam string CRLF = "\015\012";

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CODE_W-1:0] cfg_data;
  int unsigned       fail_count;
  int unsigned       verdicts_pending;

  hrp_byte_if    reply_ch ();
  hrp_verdict_if verdict_ch ();

  // Idle chances in percent for the byte sender and the verdict taker.
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 45;
  // Raised by the stimulus to make the verdict taker hold off for a long time.
  bit          long_hold_req = 1'b0;

  logic [CODE_W-1:0] active_code;
  logic [7:0]        reply_buf[$];
  int unsigned       bytes_sent   = 0;
  int unsigned       replies_sent = 0;

  http_response_header_parser dut (
    .clk         (clk),
    .rst         (rst),
    .reply_bytes (reply_ch),
    .verdict     (verdict_ch),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  http_reply_checker chk (
    .clk              (clk),
    .rst              (rst),
    .byte_ch          (reply_ch),
    .verdict_ch       (verdict_ch),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung parser or a lost verdict ends the run here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("http_response_header_parser verification failed");
        $finish;
      end
    end
  end

  // Verdict taker. It normally drops ready at random, but on request it holds
  // off for a long stretch counted here, so the parser backs up and has to
  // refuse byte requests while the sender keeps offering them.
  initial begin : verdict_taker
    int unsigned hold_left;
    hold_left = 0;
    verdict_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left     = 600;
        long_hold_req = 1'b0;
      end
      if (rst) begin
        verdict_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        verdict_ch.ready <= 1'b0;
      end else begin
        verdict_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one byte request and returns at the edge where it is taken. Valid is
  // left high afterwards, so back-to-back requests drop it only for a random idle.
  task automatic push_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      reply_ch.valid <= 1'b0;
      @(posedge clk);
    end
    reply_ch.valid     <= 1'b1;
    reply_ch.data_byte <= b;
    reply_ch.last_byte <= lst;
    @(posedge clk);
    while (!reply_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_reply();
    for (int i = 0; i < reply_buf.size(); i++)
      push_byte(reply_buf[i], i == reply_buf.size() - 1);
    replies_sent++;
    reply_buf.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) reply_buf.push_back(s[i]);
  endtask

  // The prefix code goes out least significant byte first.
  task automatic add_prefix(input logic [31:0] p);
    for (int i = 0; i < 4; i++) reply_buf.push_back(p[8*i +: 8]);
  endtask

  task automatic add_letters(input int unsigned n);
    repeat (n) reply_buf.push_back(8'h61 + 8'($urandom_range(25)));
  endtask

  task automatic directed_reply(input logic [31:0] p, input string body);
    add_prefix(p);
    add_text(body);
    send_reply();
  endtask

  // Mostly well-formed replies with random content, so the parse gets past the
  // prefix and version checks; the rest is noise, damaged tags and cut-offs.
  task automatic random_reply();
    int unsigned cut;
    int unsigned spaces;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(40, 1)) reply_buf.push_back(8'($urandom()));
    end else begin
      case ($urandom_range(9))
        0:       add_prefix($urandom());
        1:       add_prefix(32'(active_code) + 32'd1);
        default: add_prefix(32'(active_code));
      endcase
      add_text("HTTP/");
      if ($urandom_range(9) == 0) reply_buf[4 + $urandom_range(4)] = 8'($urandom());
      if ($urandom_range(3) == 0) add_letters($urandom_range(3));
      else add_text($sformatf("1.%0d", $urandom_range(9)));

      spaces = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
      repeat (spaces) reply_buf.push_back(hrp_pkg::CHAR_SPACE);
      if ($urandom_range(6) == 0)
        repeat ($urandom_range(2, 1)) reply_buf.push_back(8'($urandom_range(13, 9)));
      case ($urandom_range(19))
        0:       reply_buf.push_back(hrp_pkg::CHAR_PLUS);
        1:       reply_buf.push_back(hrp_pkg::CHAR_MINUS);
        default: ;
      endcase
      if ($urandom_range(9) == 0) add_text("00");
      case ($urandom_range(9))
        0:       add_text($sformatf("%0d", $urandom_range(1100)));
        1:       add_text($sformatf("%0d%0d", $urandom(), $urandom()));
        default: add_text($sformatf("%0d", active_code));
      endcase
      reply_buf.push_back(hrp_pkg::CHAR_SPACE);
      add_letters($urandom_range(8));

      repeat ($urandom_range(2)) begin
        add_text({CRLF, "X-Id: "});
        add_letters($urandom_range(6));
      end
      case ($urandom_range(9))
        0:       add_text({CRLF, "\015"});
        1:       add_text("\012\012");
        default: add_text({CRLF, CRLF});
      endcase
      repeat ($urandom_range(20)) reply_buf.push_back(8'($urandom()));

      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(reply_buf.size(), 1);
        while (reply_buf.size() > cut) void'(reply_buf.pop_back());
      end
    end
    send_reply();
  endtask

  // Lets every outstanding verdict drain, then waits on so that the parser
  // is idle before the code register is touched.
  task automatic settle();
    reply_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_code(input logic [CODE_W-1:0] v);
    cfg_we      <= 1'b1;
    cfg_data    <= v;
    active_code  = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random phase: a new success code, new idle rates, and a few random
  // replies. The long hold, when asked for, starts with the first of them.
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input logic [CODE_W-1:0] code, input bit with_hold);
    int unsigned byte_goal;
    int unsigned reply_goal;
    settle();
    write_code(code);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    byte_goal     = bytes_sent + 90;
    reply_goal    = replies_sent + 2;
    while (bytes_sent < byte_goal || replies_sent < reply_goal) begin
      if (with_hold && replies_sent == reply_goal - 2) long_hold_req = 1'b1;
      random_reply();
    end
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    reply_ch.valid     = 1'b0;
    reply_ch.data_byte = '0;
    reply_ch.last_byte = 1'b0;
    active_code        = hrp_pkg::SUCCESS_CODE_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed replies, success code still at its reset value.
    // Replies that end inside the prefix or right after it.
    reply_buf.push_back(8'hff);
    send_reply();
    reply_buf.push_back(8'hc8);
    reply_buf.push_back(8'h00);
    reply_buf.push_back(8'h00);
    send_reply();
    add_prefix(32'd200);
    send_reply();
    // Prefix mismatches, including the most negative and minus one.
    directed_reply(32'd201, {"HTTP/1.1 200 OK", CRLF, CRLF, "hi"});
    directed_reply(32'hffff_ffff, {"HTTP/1.1 200 OK", CRLF, CRLF, "hi"});
    directed_reply(32'h8000_0000, {"HTTP/1.1 200 OK", CRLF, CRLF, "hi"});
    // Body one short of the minimum, then exactly the minimum.
    directed_reply(32'd200, {"HTTP/ 200", CRLF, CRLF, "X"});
    directed_reply(32'd200, {"HTTP/1 200", CRLF, CRLF, "X"});
    directed_reply(32'd200, {"HTTX/1.1 200 OK", CRLF, CRLF, "ab"});
    directed_reply(32'd200, {"HTTP/1.1 200 OK", CRLF, "Server: x", CRLF, CRLF, "hello"});
    directed_reply(32'd200, {"HTTP/1.1 404 Not Found", CRLF, CRLF, "x"});
    // Control whitespace ahead of the code is skipped; a space there ends it.
    directed_reply(32'd200, {"HTTP/1.1 \011\015\012\013\014200 OK", CRLF, CRLF, "body"});
    directed_reply(32'd200, {"HTTP/1.1 \011 200 OK", CRLF, CRLF, "body"});
    // Signs, a doubled sign, and saturation at both int32 limits.
    directed_reply(32'd200, {"HTTP/1.1   +200 OK", CRLF, CRLF, "y"});
    directed_reply(32'd200, {"HTTP/1.1 -200 OK", CRLF, CRLF, "y"});
    directed_reply(32'd200, {"HTTP/1.1 --5 OK", CRLF, CRLF, "y"});
    directed_reply(32'd200, {"HTTP/1.1 99999999999 OK", CRLF, CRLF, "y"});
    directed_reply(32'd200, {"HTTP/1.1 -99999999999 OK", CRLF, CRLF, "y"});
    // No space at all, so the code token is empty.
    directed_reply(32'd200, {"HTTP/1.1-200", CRLF, CRLF, "zz"});
    // Missing blank line, and a blank line that ends on the final byte.
    directed_reply(32'd200, {"HTTP/1.1 200 OK", CRLF, "abcdef"});
    directed_reply(32'd200, {"HTTP/1.1 200 OK", CRLF, CRLF});
    // Stray CRs ahead of the blank line.
    directed_reply(32'd200, {"HTTP/1.1 200 OK\015", CRLF, "\015\015\012", CRLF, "Q"});

    // Random phases, walking the success code through 999, 0 and a random value between.
    run_phase(11, 45, CODE_W'(999), 1'b1);
    run_phase(45, 11, CODE_W'(0), 1'b0);
    run_phase(0, 0, CODE_W'($urandom_range(998, 1)), 1'b0);

    // Every verdict must have arrived; a final wait catches a stray one.
    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("http_response_header_parser verification clean");
    end else begin
      $display("http_response_header_parser verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/hrp_pkg.sv
src/hrp_if.sv
src/hrp_scan.sv
src/hrp_verdict.sv
src/http_response_header_parser.sv
bench/http_reply_checker.sv
bench/tb.sv
